@@ sv/kmc_pkg.sv @@
//------------------------------------------------------------------------------
// kmc_pkg
// Shared constants and types for the 2-D Manhattan k-means block.
//------------------------------------------------------------------------------
package kmc_pkg;

  localparam int unsigned MaxPointsDefault   = 16;
  localparam int unsigned NumClustersDefault = 3;
  localparam int unsigned CoordW             = 32;
  localparam int unsigned PassW              = 8;
  localparam int unsigned TolW               = 16;
  localparam int unsigned CfgW               = 16;
  localparam int unsigned CfgIdxW            = 1;
  localparam int unsigned CidW               = 3;

  localparam logic [CfgIdxW-1:0] RegMaxPasses = 1'b0;
  localparam logic [CfgIdxW-1:0] RegTolerance = 1'b1;

  localparam logic [PassW-1:0] MaxPassesReset = 8'd100;
  localparam logic [TolW-1:0]  ToleranceReset = 16'd1;

  // Controller to datapath commands.
  typedef struct packed {
    logic store_pt;     // write incoming point at load count
    logic init_cent;    // centroid c from point c (or zero)
    logic clr_acc;      // clear sums and counts
    logic rd_pt;        // issue store read at point index
    logic assign_pt;    // fold read point into nearest cluster
    logic div_start;    // start mean for cluster
    logic div_sel_y;    // divide y sum (else x)
    logic div_done_wr;  // write quotient to centroid
    logic snap_prev;    // snapshot centroids
    logic chk_clear;    // set settled flag
    logic chk_cent;     // compare centroid against snapshot
  } kmc_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic settled;
    logic empty_cl;     // selected cluster has no members
  } kmc_sts_t;

endpackage

@@ sv/kmc_ram.sv @@
//------------------------------------------------------------------------------
// kmc_ram
// Generic single-port RAM with registered read.
//------------------------------------------------------------------------------
module kmc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write or read one entry a cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

@@ sv/kmc_div.sv @@
//------------------------------------------------------------------------------
// kmc_div
// Signed sum over unsigned count, truncated toward zero, one quotient bit
// per cycle.
//------------------------------------------------------------------------------
module kmc_div #(
  parameter int unsigned NumW = 42,
  parameter int unsigned DenW = 11
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            busy_o,
  output logic [31:0]     quot_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            neg_q, neg_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [DenW:0]   trial;
  logic [NumW-1:0] qneg;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    trial  = {rem_q[DenW-1:0], quo_q[NumW-1]};
    if (start_i) begin
      // latch magnitude and sign
      busy_d = 1'b1;
      cnt_d  = CntW'(NumW);
      neg_d  = num_i[NumW-1];
      quo_d  = num_i[NumW-1] ? (~num_i + NumW'(1)) : num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      // shift in one bit, subtract when it fits
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign qneg   = neg_q ? (~quo_q + NumW'(1)) : quo_q;
  assign busy_o = busy_q;
  assign quot_o = qneg[31:0];

endmodule

@@ sv/kmc_datapath.sv @@
//------------------------------------------------------------------------------
// kmc_datapath
// Point store, centroids, per-cluster sums, nearest-centroid search and mean.
//------------------------------------------------------------------------------
module kmc_datapath #(
  parameter int unsigned MaxPoints   = kmc_pkg::MaxPointsDefault,
  parameter int unsigned NumClusters = kmc_pkg::NumClustersDefault,
  localparam int unsigned PtW  = $clog2(MaxPoints),
  localparam int unsigned LdW  = $clog2(MaxPoints + 1),
  localparam int unsigned ClW  = $clog2(NumClusters),
  localparam int unsigned SumW = 32 + LdW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  kmc_pkg::kmc_cmd_t             cmd_i,
  input  logic [ClW-1:0]                cl_i,
  input  logic [PtW-1:0]                pt_i,
  input  logic [kmc_pkg::TolW-1:0]      tol_i,
  input  logic signed [31:0]            point_x_i,
  input  logic signed [31:0]            point_y_i,
  input  logic [LdW-1:0]                load_cnt_i,
  output kmc_pkg::kmc_sts_t             sts_o,
  output logic signed [31:0]            cent_x_o,
  output logic signed [31:0]            cent_y_o
);

  logic signed [31:0]   cx_q [NumClusters];
  logic signed [31:0]   cy_q [NumClusters];
  logic signed [31:0]   px_q [NumClusters];
  logic signed [31:0]   py_q [NumClusters];
  logic signed [SumW-1:0] sx_q [NumClusters];
  logic signed [SumW-1:0] sy_q [NumClusters];
  logic [LdW-1:0]       mc_q [NumClusters];
  logic                 settled_q;
  logic [31:0]          rx, ry;
  logic                 we;
  logic [PtW-1:0]       addr;
  logic signed [34:0]   mdist [NumClusters];
  logic [ClW-1:0]       best;
  logic signed [34:0]   best_d;
  logic signed [32:0]   dx, dy, tx, ty;
  logic [31:0]          quot;
  logic                 div_busy;
  logic [SumW-1:0]      num;

  // store write while loading, read by index otherwise
  assign we   = cmd_i.store_pt;
  assign addr = cmd_i.store_pt ? load_cnt_i[PtW-1:0] : pt_i;

  kmc_ram #(.Width(32), .Depth(MaxPoints)) u_ram_x (
    .clk_i(clk_i), .we_i(we), .addr_i(addr), .wdata_i(point_x_i), .rdata_o(rx)
  );
  kmc_ram #(.Width(32), .Depth(MaxPoints)) u_ram_y (
    .clk_i(clk_i), .we_i(we), .addr_i(addr), .wdata_i(point_y_i), .rdata_o(ry)
  );

  // distance per centroid, strict less keeps the lower index
  always_comb begin
    for (int c = 0; c < NumClusters; c++) begin
      dx = 33'(cx_q[c]) - 33'($signed(rx));
      dy = 33'(cy_q[c]) - 33'($signed(ry));
      mdist[c] = 35'(dx[32] ? -dx : dx) + 35'(dy[32] ? -dy : dy);
    end
    best   = '0;
    best_d = mdist[0];
    for (int c = 1; c < NumClusters; c++) begin
      if (mdist[c] < best_d) begin
        best_d = mdist[c];
        best   = ClW'(c);
      end
    end
  end

  assign num = cmd_i.div_sel_y ? sy_q[cl_i] : sx_q[cl_i];

  kmc_div #(.NumW(SumW), .DenW(LdW)) u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(cmd_i.div_start),
    .num_i(num), .den_i(mc_q[cl_i]), .busy_o(div_busy), .quot_o(quot)
  );

  assign tx = 33'(cx_q[cl_i]) - 33'(px_q[cl_i]);
  assign ty = 33'(cy_q[cl_i]) - 33'(py_q[cl_i]);

  // centroid and accumulator update
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NumClusters; c++) begin
      if (cmd_i.init_cent && !cmd_i.assign_pt) begin
        cx_q[c] <= '0;
        cy_q[c] <= '0;
      end
      if (cmd_i.clr_acc) begin
        sx_q[c] <= '0;
        sy_q[c] <= '0;
        mc_q[c] <= '0;
      end
      if (cmd_i.snap_prev) begin
        px_q[c] <= cx_q[c];
        py_q[c] <= cy_q[c];
      end
    end
    if (cmd_i.init_cent && cmd_i.assign_pt) begin
      // seed centroid from point just read
      cx_q[cl_i] <= rx;
      cy_q[cl_i] <= ry;
    end else if (cmd_i.assign_pt) begin
      sx_q[best] <= sx_q[best] + SumW'($signed(rx));
      sy_q[best] <= sy_q[best] + SumW'($signed(ry));
      mc_q[best] <= mc_q[best] + LdW'(1);
    end
    if (cmd_i.div_done_wr) begin
      if (cmd_i.div_sel_y) begin
        cy_q[cl_i] <= quot;
      end else begin
        cx_q[cl_i] <= quot;
      end
    end
  end

  // convergence flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settled_q <= 1'b0;
    end else if (cmd_i.chk_clear) begin
      settled_q <= 1'b1;
    end else if (cmd_i.chk_cent) begin
      if (!((tx[32] ? -tx : tx) < 33'(tol_i) && (ty[32] ? -ty : ty) < 33'(tol_i))) begin
        settled_q <= 1'b0;
      end
    end
  end

  assign sts_o.div_busy = div_busy;
  assign sts_o.settled  = settled_q;
  assign sts_o.empty_cl = (mc_q[cl_i] == '0);
  assign cent_x_o       = cx_q[cl_i];
  assign cent_y_o       = cy_q[cl_i];

endmodule

@@ sv/kmc_ctrl.sv @@
//------------------------------------------------------------------------------
// kmc_ctrl
// Sequencer: load, seed, assign, mean, convergence check and emit.
//------------------------------------------------------------------------------
module kmc_ctrl #(
  parameter int unsigned MaxPoints   = kmc_pkg::MaxPointsDefault,
  parameter int unsigned NumClusters = kmc_pkg::NumClustersDefault,
  localparam int unsigned PtW = $clog2(MaxPoints),
  localparam int unsigned LdW = $clog2(MaxPoints + 1),
  localparam int unsigned ClW = $clog2(NumClusters)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     last_point_i,
  output logic                     out_valid,
  input  logic                     out_stall,
  input  logic [kmc_pkg::PassW-1:0] max_passes_i,
  input  kmc_pkg::kmc_sts_t        sts_i,
  output kmc_pkg::kmc_cmd_t        cmd_o,
  output logic [ClW-1:0]           cl_o,
  output logic [PtW-1:0]           pt_o,
  output logic [LdW-1:0]           load_cnt_o,
  output logic [kmc_pkg::PassW-1:0] passes_o,
  output logic                     last_o
);

  localparam logic [3:0] SLoad   = 4'd0;
  localparam logic [3:0] SSeedRd = 4'd1;
  localparam logic [3:0] SSeedWr = 4'd2;
  localparam logic [3:0] SPass   = 4'd3;
  localparam logic [3:0] SRd     = 4'd4;
  localparam logic [3:0] SAsg    = 4'd5;
  localparam logic [3:0] SDivX   = 4'd6;
  localparam logic [3:0] SWaitX  = 4'd7;
  localparam logic [3:0] SDivY   = 4'd8;
  localparam logic [3:0] SWaitY  = 4'd9;
  localparam logic [3:0] SChk    = 4'd10;
  localparam logic [3:0] SNext   = 4'd11;
  localparam logic [3:0] SEmit   = 4'd12;

  logic [3:0]                state_q, state_d;
  logic [LdW-1:0]            ld_q, ld_d;
  logic [ClW-1:0]            cl_q, cl_d;
  logic [LdW-1:0]            pt_q, pt_d;
  logic [kmc_pkg::PassW-1:0] pass_q, pass_d, limit;
  logic                      acc;

  assign limit = (max_passes_i == '0) ? kmc_pkg::PassW'(1) : max_passes_i;
  assign acc   = in_valid && (state_q == SLoad);

  always_comb begin
    state_d = state_q;
    ld_d    = ld_q;
    cl_d    = cl_q;
    pt_d    = pt_q;
    pass_d  = pass_q;
    cmd_o   = '0;
    case (state_q)
      SLoad: begin
        // store point while room remains
        if (acc) begin
          if (ld_q < LdW'(MaxPoints)) begin
            cmd_o.store_pt = 1'b1;
            ld_d = ld_q + LdW'(1);
          end
          if (last_point_i) begin
            cmd_o.init_cent = 1'b1;
            cl_d    = '0;
            state_d = SSeedRd;
          end
        end
      end
      SSeedRd: begin
        if (LdW'(cl_q) < ld_q) begin
          state_d = SSeedWr;
        end else begin
          cmd_o.clr_acc = 1'b1;
          cmd_o.snap_prev = 1'b1;
          pass_d  = '0;
          state_d = SPass;
        end
      end
      SSeedWr: begin
        cmd_o.init_cent = 1'b1;
        cmd_o.assign_pt = 1'b1;
        if (cl_q == ClW'(NumClusters - 1)) begin
          state_d = SPass;
          pass_d  = '0;
        end else begin
          cl_d    = cl_q + ClW'(1);
          state_d = SSeedRd;
        end
      end
      SPass: begin
        // begin one pass
        cmd_o.clr_acc   = 1'b1;
        cmd_o.snap_prev = 1'b1;
        cmd_o.chk_clear = 1'b1;
        pass_d  = pass_q + kmc_pkg::PassW'(1);
        pt_d    = '0;
        state_d = SRd;
      end
      SRd: begin
        state_d = SAsg;
      end
      SAsg: begin
        cmd_o.assign_pt = 1'b1;
        pt_d = pt_q + LdW'(1);
        if (pt_q + LdW'(1) < ld_q) begin
          state_d = SRd;
        end else begin
          cl_d    = '0;
          state_d = SDivX;
        end
      end
      SDivX: begin
        if (sts_i.empty_cl) begin
          state_d = SChk;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = SWaitX;
        end
      end
      SWaitX: begin
        if (!sts_i.div_busy) begin
          cmd_o.div_done_wr = 1'b1;
          state_d = SDivY;
        end
      end
      SDivY: begin
        cmd_o.div_sel_y = 1'b1;
        cmd_o.div_start = 1'b1;
        state_d = SWaitY;
      end
      SWaitY: begin
        cmd_o.div_sel_y = 1'b1;
        if (!sts_i.div_busy) begin
          cmd_o.div_done_wr = 1'b1;
          state_d = SChk;
        end
      end
      SChk: begin
        cmd_o.chk_cent = 1'b1;
        if (cl_q == ClW'(NumClusters - 1)) begin
          state_d = SNext;
        end else begin
          cl_d    = cl_q + ClW'(1);
          state_d = SDivX;
        end
      end
      SNext: begin
        cl_d = '0;
        if (sts_i.settled || pass_q >= limit) begin
          state_d = SEmit;
        end else begin
          state_d = SPass;
        end
      end
      SEmit: begin
        // drain one result per beat
        if (!out_stall) begin
          if (cl_q == ClW'(NumClusters - 1)) begin
            ld_d    = '0;
            state_d = SLoad;
          end else begin
            cl_d = cl_q + ClW'(1);
          end
        end
      end
      default: begin
        state_d = SLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SLoad;
      ld_q    <= '0;
      cl_q    <= '0;
      pt_q    <= '0;
      pass_q  <= '0;
    end else begin
      state_q <= state_d;
      ld_q    <= ld_d;
      cl_q    <= cl_d;
      pt_q    <= pt_d;
      pass_q  <= pass_d;
    end
  end

  assign in_stall   = (state_q != SLoad);
  assign out_valid  = (state_q == SEmit);
  assign cl_o       = cl_q;
  assign pt_o       = (state_q == SSeedRd) ? PtW'(cl_q) : pt_q[PtW-1:0];
  assign load_cnt_o = ld_q;
  assign passes_o   = pass_q;
  assign last_o     = (cl_q == ClW'(NumClusters - 1));

endmodule

@@ sv/kmeans_2d_manhattan_clustering_unit.sv @@
//------------------------------------------------------------------------------
// kmeans_2d_manhattan_clustering_unit
// K-means of signed Q16.16 2-D points under Manhattan distance.
//
// Channel  Direction  Handshake             Beat
// in       input      in_valid / in_stall   point_x, point_y, last_point
// out      output     out_valid / out_stall one centroid with run status
// cfg      input      cfg_we                max_passes, converge_tolerance
//
// Loading accepts one point per cycle. Each pass then reads and assigns every
// stored point and, for each non-empty cluster, runs two shift-subtract
// divisions of 32+log2(MaxPoints+1) steps, x then y, each written back once
// the divider is idle; empty clusters skip the divisions.
// Reset empties the store and returns to loading. in_stall is high from the
// last point until the final centroid beat is taken; out_stall holds a beat.
//------------------------------------------------------------------------------
module kmeans_2d_manhattan_clustering_unit #(
  parameter int unsigned MaxPoints   = kmc_pkg::MaxPointsDefault,
  parameter int unsigned NumClusters = kmc_pkg::NumClustersDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [31:0]          point_x_i,
  input  logic signed [31:0]          point_y_i,
  input  logic                        last_point_i,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [kmc_pkg::CidW-1:0]    cluster_index_o,
  output logic signed [31:0]          centroid_x_o,
  output logic signed [31:0]          centroid_y_o,
  output logic [kmc_pkg::PassW-1:0]   passes_run_o,
  output logic                        converged_o,
  output logic                        last_centroid_o,
  input  logic                        cfg_we,
  input  logic [kmc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [kmc_pkg::CfgW-1:0]    cfg_data
);

  localparam int unsigned PtW = $clog2(MaxPoints);
  localparam int unsigned LdW = $clog2(MaxPoints + 1);
  localparam int unsigned ClW = $clog2(NumClusters);

  logic [kmc_pkg::PassW-1:0] max_passes_q;
  logic [kmc_pkg::TolW-1:0]  tol_q;
  kmc_pkg::kmc_cmd_t         cmd;
  kmc_pkg::kmc_sts_t         sts;
  logic [ClW-1:0]            cl;
  logic [PtW-1:0]            pt;
  logic [LdW-1:0]            ld;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_passes_q <= kmc_pkg::MaxPassesReset;
      tol_q        <= kmc_pkg::ToleranceReset;
    end else if (cfg_we) begin
      case (cfg_index)
        kmc_pkg::RegMaxPasses: max_passes_q <= cfg_data[kmc_pkg::PassW-1:0];
        kmc_pkg::RegTolerance: tol_q        <= cfg_data;
        default: ;
      endcase
    end
  end

  kmc_ctrl #(.MaxPoints(MaxPoints), .NumClusters(NumClusters)) u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(in_valid), .in_stall(in_stall),
    .last_point_i(last_point_i), .out_valid(out_valid), .out_stall(out_stall),
    .max_passes_i(max_passes_q), .sts_i(sts), .cmd_o(cmd), .cl_o(cl),
    .pt_o(pt), .load_cnt_o(ld), .passes_o(passes_run_o), .last_o(last_centroid_o)
  );

  kmc_datapath #(.MaxPoints(MaxPoints), .NumClusters(NumClusters)) u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd), .cl_i(cl), .pt_i(pt),
    .tol_i(tol_q), .point_x_i(point_x_i), .point_y_i(point_y_i),
    .load_cnt_i(ld), .sts_o(sts), .cent_x_o(centroid_x_o), .cent_y_o(centroid_y_o)
  );

  assign cluster_index_o = kmc_pkg::CidW'(cl);
  assign converged_o     = sts.settled;

endmodule
